>>> rtl/assert_macros.svh
// Assertion macros shared by the dequantizer RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// plain check that holds during reset as well
`define ASSERT_ALWAYS(label, clk, cond, msg) \
   label: assert property (@(posedge clk) (cond)) else $error(msg);
`endif

>>> rtl/q8d_pkg.sv
// Package for the Q8_0 block dequantizer: block constants and the
// half-by-int8 product function. No dependencies.
package q8d_pkg;
   localparam int WEIGHTS_PER_BLOCK = 32;
   localparam int POS_W = $clog2(WEIGHTS_PER_BLOCK + 2);
   localparam logic [POS_W-1:0] POS_SCALE_LO = POS_W'(0);
   localparam logic [POS_W-1:0] POS_SCALE_HI = POS_W'(1);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(WEIGHTS_PER_BLOCK + 1);
   localparam logic [31:0] DEFAULT_NAN = 32'hFFC00000;
   localparam logic [30:0] INF_MAG = 31'h7F800000;
   localparam logic [4:0] EXP_MAX = 5'h1F;

   typedef logic [POS_W-1:0] pos_type;

   // weight (two's complement byte) times half scale, exact single result
   function automatic logic [31:0] mul_half_int8(input logic [15:0] half,
                                                 input logic [7:0] wbyte);
      logic       rsign;
      logic [4:0] sexp;
      logic [10:0] mag;
      logic [7:0] wmag;
      logic [18:0] prod;
      logic [4:0] p;
      logic [7:0] bexp;
      logic [22:0] frac;
      logic [41:0] sh;
      rsign = half[15] ^ wbyte[7];
      sexp = half[14:10];
      wmag = wbyte[7] ? (8'd0 - wbyte) : wbyte;
      mag = (sexp == 5'd0) ? {1'b0, half[9:0]} : {1'b1, half[9:0]};
      prod = {3'd0, wmag[7] ? 8'd128 : wmag} * 19'(mag);
      p = 5'd0;
      for (int i = 0; i < 19; i++) begin
         if (prod[i]) p = 5'(i);
      end
      bexp = 8'(p) + ((sexp == 5'd0) ? 8'd103 : (8'(sexp) + 8'd102));
      sh = {23'd0, prod} << (5'd23 - p);
      frac = sh[22:0];
      if (sexp == EXP_MAX) begin
         mul_half_int8 = (wbyte == 8'd0) ? DEFAULT_NAN : {rsign, INF_MAG};
      end else if (prod == 19'd0) begin
         mul_half_int8 = {rsign, 31'd0};
      end else begin
         mul_half_int8 = {rsign, bexp, frac};
      end
   endfunction
endpackage

>>> rtl/q8d_stream_if.sv
// Valid/ready stream interface, parameterized payload width.
// Depends on nothing.
interface q8d_stream_if #(parameter int WIDTH = 8) (input logic clock);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/q8_0_block_dequantizer.sv
// Top level of the Q8_0 block dequantizer.
// Depends on q8d_pkg, q8d_stream_if and assert_macros.svh.
//
// Usage: req carries one stream byte per transfer (data[7:0] = stream_byte).
// Each 34-byte block begins with a little-endian half scale; the two scale
// bytes give no result. Each following weight byte gives one rsp transfer,
// data[31:0] = weight_value (IEEE single), data[32] = block_end, set on the
// block's thirty-second weight.
// Timing: a weight accepted at a clock edge is offered on rsp in the cycle
// after it. Throughput: one byte per cycle while rsp is not stalled; the product
// logic sits between the req acceptance and a single output register.
// A stalled rsp holds its result; req stays ready while the output
// register is empty or being taken in the same cycle, so only a stall of
// the receiver stops the input.
// Reset (synchronous, active high) clears the byte position to the start
// of a block, the scale to zero and empties the output register.
`include "assert_macros.svh"
module q8_0_block_dequantizer (
   input logic clock,
   input logic reset,
   q8d_stream_if.sink req,
   q8d_stream_if.source rsp
);
   q8d_pkg::pos_type pos_ff, pos_in;
   logic [15:0] scale_ff, scale_in;
   logic        vld_ff, vld_in;
   logic [32:0] out_ff, out_in;
   logic        take, is_weight;

   assign req.ready = !vld_ff || rsp.ready;
   assign take = req.valid && req.ready;
   assign is_weight = (pos_ff != q8d_pkg::POS_SCALE_LO) &&
                      (pos_ff != q8d_pkg::POS_SCALE_HI);
   assign rsp.valid = vld_ff;
   assign rsp.data = out_ff;

   always_comb begin
      pos_in = pos_ff;
      scale_in = scale_ff;
      out_in = out_ff;
      vld_in = vld_ff && !rsp.ready;
      if (take) begin
         if (pos_ff == q8d_pkg::POS_SCALE_LO) begin
            scale_in = {scale_ff[15:8], req.data};
            pos_in = q8d_pkg::POS_SCALE_HI;
         end else if (pos_ff == q8d_pkg::POS_SCALE_HI) begin
            scale_in = {req.data, scale_ff[7:0]};
            pos_in = pos_ff + q8d_pkg::pos_type'(1);
         end else begin
            vld_in = 1'b1;
            out_in = {pos_ff == q8d_pkg::POS_LAST,
                      q8d_pkg::mul_half_int8(scale_ff, req.data)};
            pos_in = (pos_ff == q8d_pkg::POS_LAST) ? q8d_pkg::POS_SCALE_LO
                                                    : pos_ff + q8d_pkg::pos_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= q8d_pkg::POS_SCALE_LO;
         scale_ff <= 16'd0;
         vld_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         scale_ff <= scale_in;
         vld_ff <= vld_in;
      end
      out_ff <= out_in;
   end

   `ASSERT_IMPL(a_pos_range, clock, reset, pos_ff <= q8d_pkg::POS_LAST, "position past block")
   `ASSERT_IMPL(a_weight_out, clock, reset,
      $past(take && is_weight && !reset) |-> vld_ff, "weight lost")
   `ASSERT_IMPL(a_scale_none, clock, reset,
      (take && !is_weight && !(vld_ff && !rsp.ready)) |=> !vld_ff, "scale byte gave result")
   `ASSERT_IMPL(a_end_wrap, clock, reset,
      (take && pos_ff == q8d_pkg::POS_LAST) |=> (pos_ff == q8d_pkg::POS_SCALE_LO && out_ff[32]),
      "block end wrap")
endmodule

>>> tb/q8_0_block_dequantizer_tb.sv
// Testbench for the Q8_0 block dequantizer: drives 34-byte blocks through the
// req stream and checks each rsp weight value and block_end bit against its
// own predictor. Depends on q8d_pkg, q8d_stream_if, q8_0_block_dequantizer.
module q8_0_block_dequantizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   class weight_scoreboard;
      int unsigned position;
      logic [15:0] scale;
      logic [32:0] pending[$];
      int errors;
      int checked;

      function new();
         position = 0;
         scale = '0;
         errors = 0;
         checked = 0;
      endfunction

      function logic [31:0] scaled_weight(logic [15:0] h, logic [7:0] w);
         logic sgn;
         logic [4:0] ex;
         int unsigned wm, m, prod, p;
         int e2;
         sgn = h[15] ^ w[7];
         ex = h[14:10];
         wm = w[7] ? (256 - 32'(w)) : 32'(w);
         if (ex == q8d_pkg::EXP_MAX)
            return (wm == 0) ? q8d_pkg::DEFAULT_NAN : {sgn, q8d_pkg::INF_MAG};
         if (ex == 0) begin
            m = 32'(h[9:0]);
            e2 = -24;
         end else begin
            m = 1024 + 32'(h[9:0]);
            e2 = int'(ex) - 25;
         end
         prod = wm * m;
         if (prod == 0) return {sgn, 31'd0};
         p = 0;
         while (p < 31 && (prod >> (p + 1)) != 0) p++;
         return {sgn, 8'(int'(p) + e2 + 127), 23'((prod << (23 - p)) & 32'h7FFFFF)};
      endfunction

      function void note_byte(logic [7:0] b);
         logic last;
         if (position == 0) begin
            scale[7:0] = b;
            position = 1;
         end else if (position == 1) begin
            scale[15:8] = b;
            position = 2;
         end else begin
            last = (position >= q8d_pkg::WEIGHTS_PER_BLOCK + 1);
            pending.push_back({last, scaled_weight(scale, b)});
            position = last ? 0 : position + 1;
         end
      endfunction

      function void check_result(logic [32:0] got);
         logic [32:0] exp_v;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         exp_v = pending.pop_front();
         checked++;
         if (exp_v[31:0] !== got[31:0]) begin
            $display("%0t: weight_value expected %h actual %h", $time, exp_v[31:0], got[31:0]);
            errors++;
         end
         if (exp_v[32] !== got[32]) begin
            $display("%0t: block_end expected %b actual %b", $time, exp_v[32], got[32]);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   always #6 clock = ~clock;

   q8d_stream_if #(8) req (clock);
   q8d_stream_if #(33) rsp (clock);
   q8_0_block_dequantizer dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   weight_scoreboard board = new();
   int send_idle_pct = 13;
   int recv_idle_pct = 58;
   bit hold_rsp = 0;
   int bytes_sent = 0;

   initial begin
      req.valid = 0;
      req.data = '0;
      rsp.ready = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) board.check_result(rsp.data);
      if (!reset && req.valid && req.ready) board.note_byte(req.data);
   end

   always @(posedge clock) begin
      if (reset || hold_rsp) rsp.ready <= 0;
      else rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_byte(logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid <= 1;
      req.data <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_block(logic [15:0] sc, bit rand_w, logic [7:0] wfix);
      send_byte(sc[7:0]);
      send_byte(sc[15:8]);
      for (int i = 0; i < q8d_pkg::WEIGHTS_PER_BLOCK; i++)
         send_byte(rand_w ? 8'($urandom) : (wfix + 8'(i)));
   endtask

   task automatic drain();
      req.valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_scale();
      case ($urandom_range(7))
         0: return {1'($urandom), 5'h1F, 10'($urandom)};
         1: return {1'($urandom), 5'h00, 10'($urandom)};
         2: return {1'($urandom), 15'd0};
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: weight runs from 0x00, 0x70, 0xF0, 0x80 and 0xE8 with 1.0 and extreme scales
      send_block(16'h3C00, 0, 8'h00);
      send_block(16'hFC00, 0, 8'h70);
      send_block(16'h7E01, 0, 8'hF0);
      send_block(16'h0001, 0, 8'h80);
      send_block(16'h83FF, 0, 8'hE8);
      send_block(16'h7BFF, 0, 8'h70);
      send_block(16'h8000, 0, 8'hF0);
      drain();
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 58 : 0;
         recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 13 : 0;
         for (int k = 0; k < 17; k++) begin
            if (k == 5) fork
               begin
                  hold_rsp = 1;
                  repeat (60) @(posedge clock);
                  hold_rsp = 0;
               end
            join_none
            if ($urandom_range(9) == 0) send_byte(8'($urandom));
            send_block(pick_scale(), 1, 8'h00);
            if (k == 10) drain();
         end
      end
      drain();
      repeat (5) @(posedge clock);
      $display("Sent %0d stream bytes; checked %0d weights over random scales,",
               bytes_sent, board.checked);
      $display("including inf/NaN, subnormal and zero scales, stalls and backpressure.");
      if (board.errors == 0 && board.pending.size() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
